### hdl/fes_pkg.sv
// fire spread package: command codes, register indexes, field widths and heat palette
package fes_pkg;

    localparam int HEAT_W       = 6;
    localparam int PALETTE_SIZE = 37;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [HEAT_W-1:0] HEAT_MAX = HEAT_W'(PALETTE_SIZE - 1);

    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_SPREAD  = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_VALUE     = 2'd2;

    localparam logic [7:0] RESET_WIDTH  = 8'd128;
    localparam logic [6:0] RESET_HEIGHT = 7'd64;
    localparam logic [5:0] RESET_HOT    = 6'd26;

    function automatic logic [23:0] palette_rgb(input logic [HEAT_W-1:0] heat);
        logic [23:0] rgb;
        case (heat)
            6'd0:    rgb = 24'h070707;
            6'd1:    rgb = 24'h1F0707;
            6'd2:    rgb = 24'h2F0F07;
            6'd3:    rgb = 24'h470F07;
            6'd4:    rgb = 24'h571707;
            6'd5:    rgb = 24'h671F07;
            6'd6:    rgb = 24'h771F07;
            6'd7:    rgb = 24'h8F2707;
            6'd8:    rgb = 24'h9F2F07;
            6'd9:    rgb = 24'hAF3F07;
            6'd10:   rgb = 24'hBF4707;
            6'd11:   rgb = 24'hC74707;
            6'd12:   rgb = 24'hDF4F07;
            6'd13:   rgb = 24'hDF5707;
            6'd14:   rgb = 24'hDF5707;
            6'd15:   rgb = 24'hD75F07;
            6'd16:   rgb = 24'hD75F07;
            6'd17:   rgb = 24'hD7670F;
            6'd18:   rgb = 24'hCF6F0F;
            6'd19:   rgb = 24'hCF770F;
            6'd20:   rgb = 24'hCF7F0F;
            6'd21:   rgb = 24'hCF8717;
            6'd22:   rgb = 24'hC78717;
            6'd23:   rgb = 24'hC78F17;
            6'd24:   rgb = 24'hC7971F;
            6'd25:   rgb = 24'hBF9F1F;
            6'd26:   rgb = 24'hBF9F1F;
            6'd27:   rgb = 24'hBFA727;
            6'd28:   rgb = 24'hBFA727;
            6'd29:   rgb = 24'hBFAF2F;
            6'd30:   rgb = 24'hB7AF2F;
            6'd31:   rgb = 24'hB7B72F;
            6'd32:   rgb = 24'hB7B737;
            6'd33:   rgb = 24'hCFCF6F;
            6'd34:   rgb = 24'hDFDF9F;
            6'd35:   rgb = 24'hEFEFC7;
            6'd36:   rgb = 24'hFFFFFF;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

### hdl/fire_effect_spread.sv
// fire spread top level: heat frame memory, spread walk, readout and palette lookup
// the calc state loads spread, read and idle-code results once the output is free
// one transaction at a time (memory read, then write), config every cycle
// restart: sweeps all 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) frame memory entries
// (8192 at the default sizes), then returns its result through the calc state
// reset: registers go to their defaults at once, then the same sweep runs with cmd_stall high
module fire_effect_spread #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fes_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [1:0]                      command,
    input  logic [1:0]                      random_bits,
    input  logic [$clog2(MAX_WIDTH)-1:0]    read_x,
    input  logic [$clog2(MAX_HEIGHT)-1:0]   read_y,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [$clog2(MAX_WIDTH)-1:0]    cell_x,
    output logic [$clog2(MAX_HEIGHT)-1:0]   cell_y,
    output logic [fes_pkg::HEAT_W-1:0]      cell_heat,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic                            frame_done
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int WCW   = $clog2(MAX_WIDTH + 1);
    localparam int HCW   = $clog2(MAX_HEIGHT + 1);
    localparam int TW    = WCW + 2;
    localparam int HW    = fes_pkg::HEAT_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CALC  = 3'b010,
        S_CLEAR = 3'b100
    } state_t;

    state_t          state_reg, state_next;

    logic [7:0]      active_width_reg;
    logic [6:0]      active_height_reg;
    logic [5:0]      hot_value_reg;

    logic [XW-1:0]   walk_col_reg, walk_col_next;
    logic [YW-1:0]   walk_row_reg, walk_row_next;

    logic [1:0]      cmd_reg;
    logic [1:0]      r_reg;
    logic [XW-1:0]   x_reg;
    logic [YW-1:0]   y_reg;
    logic            done_reg;
    logic            rd_in_reg;

    logic [AW-1:0]   sweep_cnt_reg;
    logic [WCW-1:0]  sweep_w_reg;
    logic [HCW-1:0]  sweep_h_reg;
    logic [HW-1:0]   sweep_hot_reg;
    logic            sweep_reply_reg;

    logic [HW-1:0]   frame_mem [DEPTH];
    logic [HW-1:0]   mem_q_reg;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [HW-1:0]   mem_wdata;

    logic            res_valid_reg;
    logic [XW-1:0]   cell_x_reg;
    logic [YW-1:0]   cell_y_reg;
    logic [HW-1:0]   cell_heat_reg;
    logic [23:0]     rgb_reg;
    logic            frame_done_reg;

    logic [WCW-1:0]  eff_w;
    logic [HCW-1:0]  eff_h;
    logic [HW-1:0]   eff_hot;
    logic            cmd_acc;
    logic            cfg_acc;
    logic            out_free;
    logic            cursor_ok;
    logic [XW-1:0]   cur_x;
    logic [YW-1:0]   cur_y;
    logic            walk_done;
    logic            read_in_area;

    logic [TW-1:0]   drift_sum;
    logic [TW-1:0]   drift_w;
    logic [TW-1:0]   drift_w2;
    logic [TW-1:0]   drift_mod;
    logic [XW-1:0]   spread_x;
    logic [HW-1:0]   decay;
    logic [HW-1:0]   spread_heat;
    logic [HW-1:0]   read_heat;
    logic [XW-1:0]   sweep_x;
    logic [YW-1:0]   sweep_y;
    logic            sweep_end;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;

    // effective sizes
    always_comb
    begin
        if (32'(active_width_reg) < 32'd2)
            eff_w = WCW'(2);
        else if (32'(active_width_reg) > 32'(MAX_WIDTH))
            eff_w = WCW'(MAX_WIDTH);
        else
            eff_w = WCW'(active_width_reg);

        if (32'(active_height_reg) < 32'd2)
            eff_h = HCW'(2);
        else if (32'(active_height_reg) > 32'(MAX_HEIGHT))
            eff_h = HCW'(MAX_HEIGHT);
        else
            eff_h = HCW'(active_height_reg);

        if (hot_value_reg > fes_pkg::HEAT_MAX)
            eff_hot = fes_pkg::HEAT_MAX;
        else
            eff_hot = hot_value_reg;
    end

    // cursor fix and advance
    always_comb
    begin
        cursor_ok = (32'(walk_col_reg) < 32'(eff_w)) && (32'(walk_row_reg) < 32'(eff_h))
                    && (walk_row_reg != '0);
        cur_x     = cursor_ok ? walk_col_reg : '0;
        cur_y     = cursor_ok ? walk_row_reg : YW'(1);
        walk_done = 1'b0;
        if (32'(cur_y) + 32'd1 < 32'(eff_h))
        begin
            walk_row_next = cur_y + YW'(1);
            walk_col_next = cur_x;
        end
        else
        begin
            walk_row_next = YW'(1);
            if (32'(cur_x) + 32'd1 < 32'(eff_w))
                walk_col_next = cur_x + XW'(1);
            else
            begin
                walk_col_next = '0;
                walk_done     = 1'b1;
            end
        end
        read_in_area = (32'(read_x) < 32'(eff_w)) && (32'(read_y) < 32'(eff_h));
    end

    // spread arithmetic on the fetched cell
    always_comb
    begin
        drift_w   = TW'(eff_w);
        drift_w2  = drift_w << 1;
        drift_sum = TW'(x_reg) + TW'(1) + drift_w - TW'(r_reg);
        if (drift_sum >= drift_w2)
            drift_mod = drift_sum - drift_w2;
        else if (drift_sum >= drift_w)
            drift_mod = drift_sum - drift_w;
        else
            drift_mod = drift_sum;
        decay = {{(HW-2){1'b0}}, r_reg[1], 1'b0};
        if (mem_q_reg == '0)
        begin
            spread_x    = x_reg;
            spread_heat = '0;
        end
        else
        begin
            spread_x    = XW'(drift_mod);
            spread_heat = (mem_q_reg >= decay) ? mem_q_reg - decay : '0;
        end
        if (!rd_in_reg)
            read_heat = '0;
        else if (mem_q_reg > fes_pkg::HEAT_MAX)
            read_heat = fes_pkg::HEAT_MAX;
        else
            read_heat = mem_q_reg;
    end

    // sweep value
    always_comb
    begin
        sweep_x   = sweep_cnt_reg[XW-1:0];
        sweep_y   = sweep_cnt_reg[AW-1:XW];
        sweep_end = &sweep_cnt_reg;
    end

    // memory port control
    always_comb
    begin
        mem_re    = cmd_acc
                    && ((command == fes_pkg::CMD_SPREAD) || (command == fes_pkg::CMD_READ));
        mem_raddr = (command == fes_pkg::CMD_SPREAD) ? {cur_y, cur_x} : {read_y, read_x};
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
            if ((32'(sweep_y) + 32'd1 == 32'(sweep_h_reg)) && (32'(sweep_x) < 32'(sweep_w_reg)))
                mem_wdata = sweep_hot_reg;
            else
                mem_wdata = '0;
        end
        else
        begin
            mem_we    = (state_reg == S_CALC) && out_free && (cmd_reg == fes_pkg::CMD_SPREAD);
            mem_waddr = {y_reg - YW'(1), spread_x};
            mem_wdata = spread_heat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            mem_q_reg <= frame_mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                    state_next = (command == fes_pkg::CMD_RESTART) ? S_CLEAR : S_CALC;
            end
            S_CALC:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                if (sweep_end)
                    state_next = sweep_reply_reg ? S_CALC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            active_width_reg  <= fes_pkg::RESET_WIDTH;
            active_height_reg <= fes_pkg::RESET_HEIGHT;
            hot_value_reg     <= fes_pkg::RESET_HOT;
            walk_col_reg      <= '0;
            walk_row_reg      <= YW'(1);
            sweep_cnt_reg     <= '0;
            sweep_w_reg       <= WCW'(MAX_WIDTH < 128 ? MAX_WIDTH : 128);
            sweep_h_reg       <= HCW'(MAX_HEIGHT < 64 ? MAX_HEIGHT : 64);
            sweep_hot_reg     <= fes_pkg::RESET_HOT;
            sweep_reply_reg   <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_acc)
            begin
                case (cfg_index)
                    fes_pkg::CFG_ACTIVE_WIDTH:  active_width_reg  <= cfg_data;
                    fes_pkg::CFG_ACTIVE_HEIGHT: active_height_reg <= cfg_data[6:0];
                    fes_pkg::CFG_HOT_VALUE:     hot_value_reg     <= cfg_data[5:0];
                    default:                    ;
                endcase
            end

            if (state_reg == S_CLEAR)
                sweep_cnt_reg <= sweep_cnt_reg + AW'(1);

            if (cmd_acc && (command == fes_pkg::CMD_RESTART))
            begin
                sweep_cnt_reg   <= '0;
                sweep_w_reg     <= eff_w;
                sweep_h_reg     <= eff_h;
                sweep_hot_reg   <= eff_hot;
                sweep_reply_reg <= 1'b1;
                walk_col_reg    <= '0;
                walk_row_reg    <= YW'(1);
            end
            else if (cmd_acc && (command == fes_pkg::CMD_SPREAD))
            begin
                walk_col_reg <= walk_col_next;
                walk_row_reg <= walk_row_next;
            end

            if ((state_reg == S_CALC) && out_free)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            cmd_reg   <= command;
            r_reg     <= random_bits;
            rd_in_reg <= read_in_area;
            done_reg  <= walk_done;
            if (command == fes_pkg::CMD_SPREAD)
            begin
                x_reg <= cur_x;
                y_reg <= cur_y;
            end
            else
            begin
                x_reg <= read_x;
                y_reg <= read_y;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_CALC) && out_free)
        begin
            case (cmd_reg)
                fes_pkg::CMD_SPREAD:
                begin
                    cell_x_reg     <= spread_x;
                    cell_y_reg     <= y_reg - YW'(1);
                    cell_heat_reg  <= spread_heat;
                    rgb_reg        <= '0;
                    frame_done_reg <= done_reg;
                end
                fes_pkg::CMD_READ:
                begin
                    cell_x_reg     <= x_reg;
                    cell_y_reg     <= y_reg;
                    cell_heat_reg  <= read_heat;
                    rgb_reg        <= fes_pkg::palette_rgb(read_heat);
                    frame_done_reg <= 1'b0;
                end
                default:
                begin
                    cell_x_reg     <= '0;
                    cell_y_reg     <= '0;
                    cell_heat_reg  <= '0;
                    rgb_reg        <= '0;
                    frame_done_reg <= 1'b0;
                end
            endcase
        end
    end

    assign res_valid  = res_valid_reg;
    assign cell_x     = cell_x_reg;
    assign cell_y     = cell_y_reg;
    assign cell_heat  = cell_heat_reg;
    assign red        = rgb_reg[23:16];
    assign green      = rgb_reg[15:8];
    assign blue       = rgb_reg[7:0];
    assign frame_done = frame_done_reg;

    // frame memory: never a read and a write in one cycle
    assert property (@(posedge clk) disable iff (!rst_n) mem_we |-> !mem_re)
        else $error("frame memory read and write collide");

    assert property (@(posedge clk) disable iff (!rst_n) walk_row_reg != '0)
        else $error("walk cursor on row zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_CALC))
        else $error("result loaded outside calc state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && (command == fes_pkg::CMD_SPREAD)) |=> (state_reg == S_CALC))
        else $error("spread transaction did not reach calc state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!res_valid_reg || $past(res_valid_reg)))
        else $error("result raised during sweep");

endmodule

### tb/tb_fire_effect_spread.sv
// testbench for fire_effect_spread: directed and random command streams against a heat model
module tb_fire_effect_spread;

    localparam int MAX_W = 128;
    localparam int MAX_H = 64;

    localparam logic [1:0]                    CMD_SPARE = 2'd3;
    localparam logic [fes_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // palette entries 0 to 36, entry 0 in the top bits
    localparam logic [37*24-1:0] PALETTE_BITS = {
        24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707, 24'h671F07,
        24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
        24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07, 24'hD75F07, 24'hD7670F,
        24'hCF6F0F, 24'hCF770F, 24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
        24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
        24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
        24'hFFFFFF
    };

    typedef struct packed {
        logic [6:0] x;
        logic [5:0] y;
        logic [5:0] heat;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       done;
    } cell_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [fes_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fes_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           cmd_valid = 1'b0;
    logic                           cmd_stall;
    logic [1:0]                     command = '0;
    logic [1:0]                     random_bits = '0;
    logic [6:0]                     read_x = '0;
    logic [5:0]                     read_y = '0;
    logic                           res_valid;
    logic                           res_stall = 1'b0;
    logic [6:0]                     cell_x;
    logic [5:0]                     cell_y;
    logic [5:0]                     cell_heat;
    logic [7:0]                     red;
    logic [7:0]                     green;
    logic [7:0]                     blue;
    logic                           frame_done;

    fire_effect_spread u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .random_bits (random_bits),
        .read_x      (read_x),
        .read_y      (read_y),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_heat   (cell_heat),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_done  (frame_done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // model state
    logic [5:0] heat_mem [0:MAX_H-1][0:MAX_W-1];
    int         walk_col;
    int         walk_row;
    logic [7:0] width_reg;
    logic [6:0] height_reg;
    logic [5:0] hot_reg;

    cell_t pending_cells [$];
    int    fail_count = 0;
    bit    idle_on = 1'b1;
    int    hold_len = 0;

    function automatic int eff_width();
        return (width_reg < 2) ? 2 : (width_reg > MAX_W) ? MAX_W : int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg < 2) ? 2 : (height_reg > MAX_H) ? MAX_H : int'(height_reg);
    endfunction

    function automatic void restart_heat();
        int         w;
        int         h;
        logic [5:0] hot;
        w = eff_width();
        h = eff_height();
        hot = (hot_reg > fes_pkg::HEAT_MAX) ? fes_pkg::HEAT_MAX : hot_reg;
        for (int yy = 0; yy < MAX_H; yy++)
            for (int xx = 0; xx < MAX_W; xx++)
                heat_mem[yy][xx] = '0;
        for (int xx = 0; xx < w; xx++)
            heat_mem[h-1][xx] = hot;
        walk_col = 0;
        walk_row = 1;
    endfunction

    function automatic cell_t next_cell(input logic [1:0] cmd, input logic [1:0] rb,
                                        input logic [6:0] rx, input logic [5:0] ry);
        cell_t       c;
        int          w;
        int          h;
        int          x;
        int          y;
        int          p;
        int          dx;
        int          v;
        int          decay;
        logic [23:0] rgb;
        c = '0;
        w = eff_width();
        h = eff_height();
        case (cmd)
            fes_pkg::CMD_RESTART:
            begin
                restart_heat();
            end
            fes_pkg::CMD_SPREAD:
            begin
                if (walk_col >= w || walk_row >= h || walk_row == 0)
                begin
                    walk_col = 0;
                    walk_row = 1;
                end
                x = walk_col;
                y = walk_row;
                p = int'(heat_mem[y][x]);
                decay = int'(rb) & 2;
                if (p == 0)
                begin
                    dx = x;
                    v = 0;
                end
                else
                begin
                    dx = (x + 1 + w - int'(rb)) % w;
                    v = (p >= decay) ? p - decay : 0;
                end
                heat_mem[y-1][dx] = v[5:0];
                if (y + 1 < h)
                    walk_row = y + 1;
                else
                begin
                    walk_row = 1;
                    if (x + 1 < w)
                        walk_col = x + 1;
                    else
                    begin
                        walk_col = 0;
                        c.done = 1'b1;
                    end
                end
                c.x = dx[6:0];
                c.y = 6'(y - 1);
                c.heat = v[5:0];
            end
            fes_pkg::CMD_READ:
            begin
                v = 0;
                if (int'(rx) < w && int'(ry) < h)
                begin
                    v = int'(heat_mem[ry][rx]);
                    if (v > fes_pkg::PALETTE_SIZE - 1)
                        v = fes_pkg::PALETTE_SIZE - 1;
                end
                rgb = PALETTE_BITS[(fes_pkg::PALETTE_SIZE - 1 - v)*24 +: 24];
                c.x = rx;
                c.y = ry;
                c.heat = v[5:0];
                c.r = rgb[23:16];
                c.g = rgb[15:8];
                c.b = rgb[7:0];
            end
            default:
            begin
            end
        endcase
        return c;
    endfunction

    // result checking
    task automatic check_field(input string name, input int exp_val, input logic [7:0] got);
        if (got !== exp_val[7:0])
        begin
            $display("%0t mismatch %s: exp %0d got %0d", $time, name, exp_val, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cell_t c;
        if (rst_n && res_valid === 1'b1 && res_stall == 1'b0)
        begin
            if (pending_cells.size() == 0)
            begin
                $display("%0t unexpected result transaction: exp none got x %0d y %0d heat %0d",
                         $time, cell_x, cell_y, cell_heat);
                fail_count++;
            end
            else
            begin
                c = pending_cells.pop_front();
                check_field("cell_x", int'(c.x), {1'b0, cell_x});
                check_field("cell_y", int'(c.y), {2'b0, cell_y});
                check_field("cell_heat", int'(c.heat), {2'b0, cell_heat});
                check_field("red", int'(c.r), red);
                check_field("green", int'(c.g), green);
                check_field("blue", int'(c.b), blue);
                check_field("frame_done", int'(c.done), {7'b0, frame_done});
            end
        end
    end

    // receiver stall: random bursts, or a long hold when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
                res_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [1:0] rb,
                            input logic [6:0] rx, input logic [5:0] ry);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        cmd_valid   <= 1'b1;
        command     <= cmd;
        random_bits <= rb;
        read_x      <= rx;
        read_y      <= ry;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        pending_cells.push_back(next_cell(cmd, rb, rx, ry));
    endtask

    task automatic wait_drain();
        do
            @(posedge clk);
        while (pending_cells.size() != 0);
    endtask

    task automatic write_reg(input logic [fes_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            fes_pkg::CFG_ACTIVE_WIDTH:  width_reg = data;
            fes_pkg::CFG_ACTIVE_HEIGHT: height_reg = data[6:0];
            fes_pkg::CFG_HOT_VALUE:     hot_reg = data[5:0];
            default:                    ;
        endcase
    endtask

    task automatic configure(input logic [7:0] w, input logic [7:0] h, input logic [7:0] hot);
        if (cmd_valid)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        wait_drain();
        write_reg(fes_pkg::CFG_ACTIVE_WIDTH, w);
        write_reg(fes_pkg::CFG_ACTIVE_HEIGHT, h);
        write_reg(fes_pkg::CFG_HOT_VALUE, hot);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_mixed();
        int         k;
        logic [1:0] cmd;
        logic [6:0] rx;
        logic [5:0] ry;
        k = $urandom_range(0, 99);
        rx = 7'($urandom_range(0, 127));
        ry = 6'($urandom_range(0, 63));
        if (k == 0)
            cmd = fes_pkg::CMD_RESTART;
        else if (k < 72)
            cmd = fes_pkg::CMD_SPREAD;
        else if (k < 95)
        begin
            cmd = fes_pkg::CMD_READ;
            if ($urandom_range(0, 3) != 0)
            begin
                rx = 7'($urandom_range(0, eff_width() - 1));
                ry = 6'($urandom_range(0, eff_height() - 1));
            end
        end
        else
            cmd = CMD_SPARE;
        send_cmd(cmd, 2'($urandom_range(0, 3)), rx, ry);
    endtask

    task automatic random_config();
        logic [7:0] w;
        logic [7:0] h;
        logic [7:0] hot;
        if ($urandom_range(0, 4) != 0)
        begin
            w = 8'($urandom_range(2, 9));
            h = 8'($urandom_range(2, 6));
        end
        else
        begin
            w = 8'($urandom_range(0, 255));
            h = 8'($urandom_range(0, 255));
        end
        hot = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(1, 36));
        configure(w, h, hot);
    endtask

    task automatic test_reset_frame();
        send_cmd(fes_pkg::CMD_READ, 2'd0, 7'd0, 6'd63);
        send_cmd(fes_pkg::CMD_READ, 2'd3, 7'd127, 6'd63);
        send_cmd(fes_pkg::CMD_READ, 2'd1, 7'd127, 6'd0);
        send_cmd(fes_pkg::CMD_SPREAD, 2'd3, 7'd0, 6'd0);
    endtask

    task automatic test_hot_and_clamp();
        // sizes below the minimum, hot value above the palette
        configure(8'd0, 8'd1, 8'd63);
        send_cmd(fes_pkg::CMD_RESTART, 2'd0, 7'd0, 6'd0);
        send_cmd(fes_pkg::CMD_SPREAD, 2'd0, 7'd0, 6'd0);
        send_cmd(fes_pkg::CMD_SPREAD, 2'd2, 7'd0, 6'd0);
        send_cmd(fes_pkg::CMD_READ, 2'd0, 7'd0, 6'd0);
        send_cmd(fes_pkg::CMD_READ, 2'd0, 7'd1, 6'd0);
        // upper bits of the hot value are dropped
        configure(8'd2, 8'd2, 8'd64);
        send_cmd(fes_pkg::CMD_RESTART, 2'd0, 7'd0, 6'd0);
        send_cmd(fes_pkg::CMD_READ, 2'd0, 7'd1, 6'd1);
        send_cmd(fes_pkg::CMD_SPREAD, 2'd1, 7'd0, 6'd0);
    endtask

    task automatic test_size_extremes();
        configure(8'd255, 8'd127, 8'd35);
        send_cmd(fes_pkg::CMD_RESTART, 2'd0, 7'd0, 6'd0);
        send_cmd(fes_pkg::CMD_READ, 2'd0, 7'd127, 6'd63);
        send_cmd(fes_pkg::CMD_READ, 2'd0, 7'd0, 6'd0);
    endtask

    task automatic test_read_outside();
        configure(8'd3, 8'd3, 8'd20);
        send_cmd(fes_pkg::CMD_RESTART, 2'd0, 7'd0, 6'd0);
        send_cmd(fes_pkg::CMD_READ, 2'd0, 7'd3, 6'd1);
        send_cmd(fes_pkg::CMD_READ, 2'd0, 7'd1, 6'd3);
        send_cmd(fes_pkg::CMD_READ, 2'd0, 7'd2, 6'd2);
    endtask

    task automatic test_cursor_outside();
        send_cmd(fes_pkg::CMD_SPREAD, 2'd1, 7'd0, 6'd0);
        send_cmd(fes_pkg::CMD_SPREAD, 2'd2, 7'd0, 6'd0);
        send_cmd(fes_pkg::CMD_SPREAD, 2'd3, 7'd0, 6'd0);
        // shrinking the height leaves the cursor row outside the frame
        configure(8'd3, 8'd2, 8'd20);
        send_cmd(fes_pkg::CMD_SPREAD, 2'd0, 7'd0, 6'd0);
    endtask

    task automatic test_unused_code();
        cmd_valid <= 1'b0;
        wait_drain();
        write_reg(CFG_SPARE, 8'hFF);
        cfg_valid <= 1'b0;
        send_cmd(CMD_SPARE, 2'd3, 7'd127, 6'd63);
    endtask

    task automatic test_backpressure();
        configure(8'd6, 8'd5, 8'd30);
        send_cmd(fes_pkg::CMD_RESTART, 2'd0, 7'd0, 6'd0);
        hold_len = 300;
        repeat (40) send_mixed();
    endtask

    task automatic test_drain_pause();
        repeat (20) send_mixed();
        cmd_valid <= 1'b0;
        wait_drain();
        repeat (20) send_mixed();
    endtask

    task automatic test_random_phases();
        repeat (22)
        begin
            random_config();
            send_cmd(fes_pkg::CMD_RESTART, 2'($urandom_range(0, 3)),
                     7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)));
            repeat (60) send_mixed();
        end
    endtask

    task automatic test_tail();
        random_config();
        send_cmd(fes_pkg::CMD_RESTART, 2'd0, 7'd0, 6'd0);
        idle_on = 1'b0;
        repeat (250) send_mixed();
    endtask

    initial
    begin
        width_reg  = fes_pkg::RESET_WIDTH;
        height_reg = fes_pkg::RESET_HEIGHT;
        hot_reg    = fes_pkg::RESET_HOT;
        restart_heat();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_frame();
        test_hot_and_clamp();
        test_size_extremes();
        test_read_outside();
        test_cursor_outside();
        test_unused_code();
        test_backpressure();
        test_drain_pause();
        test_random_phases();
        test_tail();
        cmd_valid <= 1'b0;
        wait_drain();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule
